// ===== src/bpmc_pkg.sv =====
// Package for the battery power mode controller.
// Holds window and level constants, mode and op codes and datapath widths.
// No dependencies.
`timescale 1ns / 1ps

package bpmc_pkg;

  localparam int WIN_LEN       = 25;
  localparam int MAX_PROCS     = 64;
  localparam int PERF_MARGIN   = 15;
  localparam int CRIT_MARGIN   = 5;
  localparam int CHARGE_STEP   = 3;
  localparam int FULL_LEVEL    = 100;
  localparam int DRAIN_MAX     = 63;
  localparam int TL_MAX        = 4095;

  localparam int LVL_W  = 7;
  localparam int DRN_W  = 6;
  localparam int WIN_W  = $clog2(WIN_LEN);
  localparam int DVD_W  = $clog2(FULL_LEVEL * WIN_LEN + 1);
  localparam int DSR_W  = DRN_W;
  localparam int TL_W   = 13;
  localparam int CNT_W  = 16;
  localparam int CHG_W  = 32;

  localparam int CFG_IDX_W = 1;
  localparam int CFG_DAT_W = 7;

  localparam logic [CFG_IDX_W-1:0] REG_SAVER_THR = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CRIT_THR  = 1'd1;

  localparam logic [1:0] OP_TICK = 2'd0;
  localparam logic [1:0] OP_SET  = 2'd1;
  localparam logic [1:0] OP_EVAL = 2'd2;

  typedef enum logic [1:0] {
    MODE_PERF  = 2'd0,
    MODE_SAVER = 2'd1,
    MODE_CRIT  = 2'd2
  } mode_t;

  typedef struct packed {
    logic             done;
    logic [DVD_W-1:0] quotient;
  } div_stat_t;

endpackage

// ===== src/bpmc_div.sv =====
// Serial restoring divider, one quotient bit per cycle.
// Dividend DVD_W bits, divisor DSR_W bits; depends on bpmc_pkg.
`timescale 1ns / 1ps

module bpmc_div (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  input  logic [bpmc_pkg::DVD_W-1:0] dividend,
  input  logic [bpmc_pkg::DSR_W-1:0] divisor,
  output bpmc_pkg::div_stat_t       stat
);
  import bpmc_pkg::*;

  localparam int STEP_W = $clog2(DVD_W + 1);

  logic [DSR_W-1:0]  rem_r, rem_nxt;
  logic [DVD_W-1:0]  quo_r, quo_nxt;
  logic [DSR_W-1:0]  dsr_r;
  logic [STEP_W-1:0] step_r, step_nxt;
  logic              busy_r, busy_nxt;
  logic              done_r, done_nxt;
  logic [DSR_W:0]    trial;
  logic              ge;

  always_comb begin
    trial    = {rem_r, quo_r[DVD_W-1]};
    ge       = trial >= {1'b0, dsr_r};
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    step_nxt = step_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      rem_nxt  = '0;
      quo_nxt  = dividend;
      step_nxt = STEP_W'(DVD_W);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      rem_nxt  = ge ? DSR_W'(trial - {1'b0, dsr_r}) : trial[DSR_W-1:0];
      quo_nxt  = {quo_r[DVD_W-2:0], ge};
      step_nxt = step_r - STEP_W'(1);
      if (step_r == STEP_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      step_r <= step_nxt;
    end
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    if (start) begin
      dsr_r <= divisor;
    end
  end

  assign stat.done     = done_r;
  assign stat.quotient = quo_r;

endmodule

// ===== src/battery_power_mode_controller_unit.sv =====
// Top level of the battery power mode controller.
// Sequencer, level and mode state, counters; uses bpmc_pkg and bpmc_div.
//
// channel  | direction | handshake            | payload
// in_      | slave     | in_tvalid/in_tready  | in_tuser op, in_tdata item fields
// out_     | master    | out_tvalid/out_tready| out_tdata result fields
// cfg_     | slave     | cfg_valid/cfg_ready  | cfg_index, cfg_data
//
// Each item passes through S_IDLE (accept), S_UPDATE (update state, start
// the divider), S_DIV (DVD_W divider steps, then wait for its done flag) and
// S_OUT (load the output register). in_tready is high only while idle; a
// result waiting in the output register does not block acceptance of the next
// item, but holds that item in its output step until the result is taken.
// rst_n is synchronous, active low; cfg_ready is always high.
`timescale 1ns / 1ps

module battery_power_mode_controller_unit (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_tvalid,
  output logic                           in_tready,
  // [1:0] op
  input  logic [1:0]                     in_tuser,
  // [6:0] runnable_count, [13:7] new_level, [14] charger_on, [15] zero
  input  logic [15:0]                    in_tdata,
  output logic                           out_tvalid,
  input  logic                           out_tready,
  // [0] status, [7:1] level_now, [9:8] mode_now, [10] mode_flip,
  // [11] exhausted, [12] exhausted_first, [18:13] drain_now,
  // [31:19] ticks_left, [63:32] charge_time, [79:64] saver_count,
  // [95:80] performance_count, [111:96] critical_count
  output logic [111:0]                   out_tdata,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [bpmc_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [bpmc_pkg::CFG_DAT_W-1:0] cfg_data
);
  import bpmc_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE   = 4'b0001,
    S_UPDATE = 4'b0010,
    S_DIV    = 4'b0100,
    S_OUT    = 4'b1000
  } state_t;

  state_t state_r, state_nxt;

  logic [6:0]       sthr_r;
  logic [5:0]       cthr_r;

  logic [1:0]       op_r;
  logic [6:0]       run_r;
  logic [LVL_W-1:0] nl_r;
  logic             chg_on_r;

  logic [LVL_W-1:0] level_r, level_nxt;
  mode_t            mode_r, mode_nxt;
  logic [WIN_W-1:0] win_r, win_nxt;
  logic [DRN_W-1:0] drain_r, drain_nxt;
  logic [CHG_W-1:0] charge_r, charge_nxt;
  logic [CNT_W-1:0] saver_r, saver_nxt;
  logic [CNT_W-1:0] perf_r, perf_nxt;
  logic [CNT_W-1:0] crit_r, crit_nxt;
  logic             exh_seen_r, exh_seen_nxt;

  logic             status_r, status_nxt;
  logic             changed_r, changed_nxt;
  logic             exh_r, exh_nxt;
  logic             exh_first_r, exh_first_nxt;

  logic             out_valid_r;
  logic [111:0]     out_data_r;

  logic [6:0]       rc;
  logic [6:0]       d7;
  logic [7:0]       lvl8;
  logic [CHG_W-1:0] charge_base;
  logic [LVL_W-1:0] eval_lvl;
  logic             do_eval;
  mode_t            mode_eval;
  logic [TL_W-1:0]  ticks_left;

  div_stat_t        div_stat;
  logic             div_start;
  logic [DVD_W-1:0] div_dividend;

  function automatic mode_t eval_mode(input logic [LVL_W-1:0] lvl, input mode_t cur,
                                      input logic [6:0] sthr, input logic [5:0] cthr);
    logic [7:0] crit_up;
    logic [7:0] save_up;
    mode_t      m;
    crit_up = {2'b00, cthr} + 8'(CRIT_MARGIN);
    save_up = {1'b0, sthr} + 8'(PERF_MARGIN);
    m       = cur;
    if (lvl <= {1'b0, cthr}) begin
      m = MODE_CRIT;
    end else if (cur == MODE_CRIT) begin
      if ({1'b0, lvl} >= crit_up) begin
        m = MODE_SAVER;
      end
    end else if (lvl <= sthr) begin
      m = MODE_SAVER;
    end else if ({1'b0, lvl} >= save_up) begin
      m = MODE_PERF;
    end
    return m;
  endfunction

  assign in_tready  = (state_r == S_IDLE);
  assign cfg_ready  = 1'b1;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  always_comb begin
    level_nxt     = level_r;
    win_nxt       = win_r;
    drain_nxt     = drain_r;
    saver_nxt     = saver_r;
    perf_nxt      = perf_r;
    crit_nxt      = crit_r;
    exh_seen_nxt  = exh_seen_r;
    status_nxt    = 1'b0;
    changed_nxt   = 1'b0;
    exh_nxt       = 1'b0;
    exh_first_nxt = 1'b0;
    do_eval       = 1'b0;
    rc            = (32'(run_r) > MAX_PROCS) ? 7'(MAX_PROCS) : run_r;
    d7            = 7'd1 + {1'b0, rc[6:1]};
    lvl8          = {1'b0, level_r} + 8'(CHARGE_STEP);
    charge_base   = chg_on_r ? charge_r : '0;
    charge_nxt    = charge_base;

    case (mode_r)
      MODE_CRIT:  d7 = 7'd1;
      MODE_SAVER: d7 = 7'((8'(d7) + 8'd1) >> 1);
      default:    d7 = d7;
    endcase
    if (32'(d7) > DRAIN_MAX) begin
      d7 = 7'(DRAIN_MAX);
    end

    case (op_r)
      OP_TICK: begin
        if (win_r == WIN_W'(WIN_LEN - 1)) begin
          win_nxt   = '0;
          drain_nxt = d7[DRN_W-1:0];
          if (chg_on_r) begin
            if (charge_base > CHG_W'(32'hFFFF_FFFF - WIN_LEN)) begin
              charge_nxt = '1;
            end else begin
              charge_nxt = charge_base + CHG_W'(WIN_LEN);
            end
            level_nxt = (32'(lvl8) > FULL_LEVEL) ? LVL_W'(FULL_LEVEL) : lvl8[LVL_W-1:0];
          end else begin
            level_nxt = (level_r > {1'b0, d7[DRN_W-1:0]}) ?
                        level_r - {1'b0, d7[DRN_W-1:0]} : '0;
          end
          do_eval = 1'b1;
        end else begin
          win_nxt = win_r + WIN_W'(1);
        end
      end
      OP_SET: begin
        if (32'(nl_r) > FULL_LEVEL) begin
          status_nxt = 1'b1;
        end else begin
          level_nxt = nl_r;
          do_eval   = 1'b1;
        end
      end
      OP_EVAL: begin
        do_eval = 1'b1;
      end
      default: begin
        do_eval = 1'b0;
      end
    endcase

    eval_lvl  = level_nxt;
    mode_eval = eval_mode(eval_lvl, mode_r, sthr_r, cthr_r);
    mode_nxt  = do_eval ? mode_eval : mode_r;
    if (do_eval && (mode_eval != mode_r)) begin
      changed_nxt = 1'b1;
      case (mode_eval)
        MODE_SAVER: saver_nxt = saver_r + CNT_W'(1);
        MODE_PERF:  perf_nxt  = perf_r + CNT_W'(1);
        default:    crit_nxt  = crit_r + CNT_W'(1);
      endcase
    end

    if (op_r == OP_TICK && win_r == WIN_W'(WIN_LEN - 1)) begin
      if (level_nxt == '0 && !chg_on_r) begin
        exh_nxt = 1'b1;
        if (!exh_seen_r) begin
          exh_seen_nxt  = 1'b1;
          exh_first_nxt = 1'b1;
        end
      end else begin
        exh_seen_nxt = 1'b0;
      end
    end
  end

  assign div_start    = (state_r == S_UPDATE);
  assign div_dividend = DVD_W'(32'(level_nxt) * WIN_LEN);

  bpmc_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (drain_nxt),
    .stat     (div_stat)
  );

  always_comb begin
    if (chg_on_r) begin
      ticks_left = '1;
    end else if (32'(div_stat.quotient) > TL_MAX) begin
      ticks_left = TL_W'(TL_MAX);
    end else begin
      ticks_left = TL_W'(div_stat.quotient);
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE:   if (in_tvalid) state_nxt = S_UPDATE;
      S_UPDATE: state_nxt = S_DIV;
      S_DIV:    if (div_stat.done) state_nxt = S_OUT;
      S_OUT:    if (!out_valid_r || out_tready) state_nxt = S_IDLE;
      default:  state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      sthr_r      <= 7'd25;
      cthr_r      <= 6'd10;
      level_r     <= LVL_W'(FULL_LEVEL);
      mode_r      <= MODE_PERF;
      win_r       <= '0;
      drain_r     <= DRN_W'(1);
      charge_r    <= '0;
      saver_r     <= '0;
      perf_r      <= CNT_W'(1);
      crit_r      <= '0;
      exh_seen_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_valid) begin
        case (cfg_index)
          REG_SAVER_THR: sthr_r <= cfg_data;
          REG_CRIT_THR:  cthr_r <= cfg_data[5:0];
          default:       sthr_r <= sthr_r;
        endcase
      end
      if (state_r == S_UPDATE) begin
        level_r    <= level_nxt;
        mode_r     <= mode_nxt;
        win_r      <= win_nxt;
        drain_r    <= drain_nxt;
        charge_r   <= charge_nxt;
        saver_r    <= saver_nxt;
        perf_r     <= perf_nxt;
        crit_r     <= crit_nxt;
        exh_seen_r <= exh_seen_nxt;
      end
      if (state_r == S_OUT && (!out_valid_r || out_tready)) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end

    if (state_r == S_IDLE && in_tvalid) begin
      op_r     <= in_tuser;
      run_r    <= in_tdata[6:0];
      nl_r     <= in_tdata[13:7];
      chg_on_r <= in_tdata[14];
    end
    if (state_r == S_UPDATE) begin
      status_r    <= status_nxt;
      changed_r   <= changed_nxt;
      exh_r       <= exh_nxt;
      exh_first_r <= exh_first_nxt;
    end
    if (state_r == S_OUT && (!out_valid_r || out_tready)) begin
      out_data_r <= {crit_r, perf_r, saver_r, charge_r, ticks_left, drain_r,
                     exh_first_r, exh_r, changed_r, mode_r, level_r, status_r};
    end
  end

endmodule
